### sv/bwf_pkg.sv
package bwf_pkg;

   localparam int MAX_WIDTH_DEF     = 256;
   localparam int MAX_HEIGHT_DEF    = 256;
   localparam int MAX_WINDOW_DEF    = 9;
   localparam int RANGE_ENTRIES     = 256;
   localparam int WEIGHT_W          = 16;
   localparam int PROD_W            = 32;
   localparam int DEN_W             = 40;
   localparam int NUM_W             = 48;
   localparam int QUOT_W            = 8;

   typedef enum logic [1:0] {
      ACT_WRITE_PIXEL   = 2'd0,
      ACT_WRITE_SPATIAL = 2'd1,
      ACT_WRITE_RANGE   = 2'd2,
      ACT_FILTER        = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2,
      REG_RANGE  = 2'd3
   } reg_addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENTRE_ADDR,
      ST_CENTRE_WAIT,
      ST_TAP_ADDR,
      ST_TAP_PIX,
      ST_TAP_RANGE,
      ST_TAP_MUL1,
      ST_TAP_MUL2,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [7:0]  pixel_value;
      logic [3:0]  weight_row;
      logic [3:0]  weight_col;
      logic [7:0]  range_index;
      logic [15:0] weight_value;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_value;
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic       zero_weight;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
      logic zero;
   } div_ctl_type;

endpackage

### sv/bilateral_window_filter_top.sv
// Bilateral / Gaussian window filter over a stored 8-bit grayscale frame.
// Input channel: req_start with req_payload; a transfer is taken when
// req_start is high and req_busy is low. Actions write a pixel, a spatial
// weight or a range weight (no result) or filter a pixel.
// A filter item walks the window one tap at a time through a single shared
// 32x16 multiplier: a centre read, then per tap the address, pixel, range
// and two multiply states, then a 48-step restoring divider. A new filter
// transfer is taken only once the last item is done; writes are taken every
// cycle while no filter item is in progress.
// The result appears on rsp_payload for one cycle with rsp_valid; the
// receiver cannot stall. req_busy stays high for the whole item.
// Registers on the csr_ port: width, height, radius, range enable at
// byte addresses 0, 4, 8, 12. Reset clears control state and loads
// the register defaults 256, 256, 2, 1; the frame and weight stores are
// not cleared and must be written before they are read.
module bilateral_window_filter_top #(
   parameter int MAX_WIDTH  = bwf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bwf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_WINDOW = bwf_pkg::MAX_WINDOW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   input  bwf_pkg::req_type     req_payload,
   output logic                 req_busy,
   output logic                 rsp_valid,
   output bwf_pkg::rsp_type     rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)
                           ? $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int SW     = MAX_WINDOW * MAX_WINDOW;
   localparam int SA     = $clog2(SW) > 0 ? $clog2(SW) : 1;
   localparam int RMAX   = (MAX_WINDOW - 1) / 2;
   localparam int TW     = 4;
   localparam int CW     = 10;

   logic [8:0] width_ff, height_ff;
   logic [2:0] radius_ff;
   logic       range_en_ff;

   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd256;
         height_ff   <= 9'd256;
         radius_ff   <= 3'd2;
         range_en_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (bwf_pkg::reg_addr_type'(csr_paddr[3:2]))
            bwf_pkg::REG_WIDTH:  width_ff    <= csr_pwdata[8:0];
            bwf_pkg::REG_HEIGHT: height_ff   <= csr_pwdata[8:0];
            bwf_pkg::REG_RADIUS: radius_ff   <= csr_pwdata[2:0];
            bwf_pkg::REG_RANGE:  range_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (bwf_pkg::reg_addr_type'(csr_paddr[3:2]))
         bwf_pkg::REG_WIDTH:  csr_prdata = {23'd0, width_ff};
         bwf_pkg::REG_HEIGHT: csr_prdata = {23'd0, height_ff};
         bwf_pkg::REG_RADIUS: csr_prdata = {29'd0, radius_ff};
         bwf_pkg::REG_RANGE:  csr_prdata = {31'd0, range_en_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // effective dims and radius
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [2:0]       r_eff;
   always_comb begin
      if (width_ff == 9'd0)                         w_eff = DIM_W'(1);
      else if ({23'd0, width_ff} > 32'(MAX_WIDTH))  w_eff = DIM_W'(MAX_WIDTH);
      else                                          w_eff = DIM_W'(width_ff);
      if (height_ff == 9'd0)                        h_eff = DIM_W'(1);
      else if ({23'd0, height_ff} > 32'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      else                                          h_eff = DIM_W'(height_ff);
      r_eff = ({29'd0, radius_ff} > 32'(RMAX)) ? 3'(RMAX) : radius_ff;
   end

   // stores
   logic [7:0]  frame_mem   [2**(YW+XW)];
   logic [15:0] spatial_mem [SW];
   logic [15:0] range_mem   [bwf_pkg::RANGE_ENTRIES];

   bwf_pkg::state_type state_ff, state_in;
   bwf_pkg::req_type   item_ff;
   logic               accept;
   assign accept = req_start && !req_busy;

   logic [YW+XW-1:0] frame_raddr;
   logic [SA-1:0]    sp_raddr;
   logic [7:0]       rg_raddr;
   logic [7:0]       pix_rd_ff;
   logic [15:0]      sp_rd_ff, rg_rd_ff;

   always_ff @(posedge clock) begin
      if (accept && req_payload.action == bwf_pkg::ACT_WRITE_PIXEL &&
          32'(req_payload.pixel_x) < 32'(MAX_WIDTH) &&
          32'(req_payload.pixel_y) < 32'(MAX_HEIGHT))
         frame_mem[{YW'(req_payload.pixel_y), XW'(req_payload.pixel_x)}] <=
            req_payload.pixel_value;
      pix_rd_ff <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.action == bwf_pkg::ACT_WRITE_SPATIAL &&
          32'(req_payload.weight_row) < 32'(MAX_WINDOW) &&
          32'(req_payload.weight_col) < 32'(MAX_WINDOW))
         spatial_mem[SA'(32'(req_payload.weight_row) * MAX_WINDOW
                         + 32'(req_payload.weight_col))] <= req_payload.weight_value;
      sp_rd_ff <= spatial_mem[sp_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.action == bwf_pkg::ACT_WRITE_RANGE)
         range_mem[req_payload.range_index] <= req_payload.weight_value;
      rg_rd_ff <= range_mem[rg_raddr];
   end

   // window walk
   logic [TW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SA-1:0] sp_idx_ff, sp_idx_in;
   logic [7:0]    centre_ff;
   logic [7:0]    p_ff;
   logic [bwf_pkg::PROD_W-1:0] wt_ff;
   logic [bwf_pkg::NUM_W-1:0]  num_ff;
   logic [bwf_pkg::DEN_W-1:0]  den_ff;
   logic [TW-1:0] span;
   assign span = TW'({r_eff, 1'b0});

   // neighbour coordinates; those outside the frame are set to 0
   logic signed [CW-1:0] nxs, nys;
   logic [XW-1:0] nx;
   logic [YW-1:0] ny;
   always_comb begin
      nxs = $signed({2'b00, item_ff.pixel_x}) + $signed({{(CW-TW){1'b0}}, dx_ff})
            - $signed({{(CW-3){1'b0}}, r_eff});
      nys = $signed({2'b00, item_ff.pixel_y}) + $signed({{(CW-TW){1'b0}}, dy_ff})
            - $signed({{(CW-3){1'b0}}, r_eff});
      if (nxs < 0 || 32'(nxs) >= 32'(w_eff)) nx = '0;
      else                                   nx = XW'(nxs);
      if (nys < 0 || 32'(nys) >= 32'(h_eff)) ny = '0;
      else                                   ny = YW'(nys);
   end

   logic [7:0] cx8, cy8;
   always_comb begin
      cx8 = (32'(item_ff.pixel_x) >= 32'(w_eff)) ? 8'd0 : item_ff.pixel_x;
      cy8 = (32'(item_ff.pixel_y) >= 32'(h_eff)) ? 8'd0 : item_ff.pixel_y;
   end

   logic [7:0] diff;
   assign diff = (pix_rd_ff > centre_ff) ? pix_rd_ff - centre_ff : centre_ff - pix_rd_ff;

   // shared multiplier: stage 1 s*g, stage 2 wt*p
   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_p;
   assign mul_p = mul_a * mul_b;
   always_comb begin
      if (state_ff == bwf_pkg::ST_TAP_MUL1) begin
         mul_a = {16'd0, sp_rd_ff};
         mul_b = range_en_ff ? rg_rd_ff : 16'd1;
      end else begin
         mul_a = wt_ff;
         mul_b = {8'd0, p_ff};
      end
   end

   always_comb begin
      frame_raddr = {ny, nx};
      if (state_ff == bwf_pkg::ST_CENTRE_ADDR) frame_raddr = {YW'(cy8), XW'(cx8)};
      sp_raddr = sp_idx_ff;
      rg_raddr = diff;
   end

   logic last_tap;
   assign last_tap = (dx_ff == span) && (dy_ff == span);

   logic div_start;
   bwf_pkg::div_ctl_type div_st;
   logic [7:0] quot;

   bwf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (num_ff),
      .denom    (den_ff),
      .status   (div_st),
      .quotient (quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bwf_pkg::ST_IDLE:
            if (accept && req_payload.action == bwf_pkg::ACT_FILTER)
               state_in = bwf_pkg::ST_CENTRE_ADDR;
         bwf_pkg::ST_CENTRE_ADDR: state_in = bwf_pkg::ST_CENTRE_WAIT;
         bwf_pkg::ST_CENTRE_WAIT: state_in = bwf_pkg::ST_TAP_ADDR;
         bwf_pkg::ST_TAP_ADDR:    state_in = bwf_pkg::ST_TAP_PIX;
         bwf_pkg::ST_TAP_PIX:     state_in = bwf_pkg::ST_TAP_RANGE;
         bwf_pkg::ST_TAP_RANGE:   state_in = bwf_pkg::ST_TAP_MUL1;
         bwf_pkg::ST_TAP_MUL1:    state_in = bwf_pkg::ST_TAP_MUL2;
         bwf_pkg::ST_TAP_MUL2:
            state_in = last_tap ? bwf_pkg::ST_DIV_START : bwf_pkg::ST_TAP_ADDR;
         bwf_pkg::ST_DIV_START:   state_in = bwf_pkg::ST_DIV_WAIT;
         bwf_pkg::ST_DIV_WAIT:
            if (div_st.done) state_in = bwf_pkg::ST_DONE;
         bwf_pkg::ST_DONE:        state_in = bwf_pkg::ST_IDLE;
         default:                 state_in = bwf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sp_idx_in = sp_idx_ff;
      div_start = 1'b0;
      unique case (state_ff)
         bwf_pkg::ST_CENTRE_ADDR: begin
            dx_in     = '0;
            dy_in     = '0;
            sp_idx_in = '0;
         end
         bwf_pkg::ST_TAP_MUL2: begin
            if (dx_ff == span) begin
               dx_in     = '0;
               dy_in     = dy_ff + 1'b1;
               sp_idx_in = SA'(32'(dy_ff + 1'b1) * MAX_WINDOW);
            end else begin
               dx_in     = dx_ff + 1'b1;
               sp_idx_in = sp_idx_ff + 1'b1;
            end
         end
         bwf_pkg::ST_DIV_START: div_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bwf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sp_idx_ff <= sp_idx_in;
      if (accept) item_ff <= req_payload;
      if (state_ff == bwf_pkg::ST_CENTRE_WAIT) centre_ff <= pix_rd_ff;
      if (state_ff == bwf_pkg::ST_TAP_PIX) p_ff <= pix_rd_ff;
      if (state_ff == bwf_pkg::ST_CENTRE_ADDR) begin
         num_ff <= '0;
         den_ff <= '0;
      end
      if (state_ff == bwf_pkg::ST_TAP_MUL1) wt_ff <= mul_p[31:0];
      if (state_ff == bwf_pkg::ST_TAP_MUL2) begin
         num_ff <= num_ff + bwf_pkg::NUM_W'(mul_p[39:0]);
         den_ff <= den_ff + bwf_pkg::DEN_W'(wt_ff);
      end
   end

   assign req_busy  = (state_ff != bwf_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == bwf_pkg::ST_DONE);
   always_comb begin
      rsp_payload.out_x          = item_ff.pixel_x;
      rsp_payload.out_y          = item_ff.pixel_y;
      rsp_payload.zero_weight    = div_st.zero;
      rsp_payload.filtered_value = div_st.zero ? 8'd0 : quot;
   end

`ifndef SYNTHESIS
   a_rsp_only_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(div_st.done)) else $error("result without division");
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_busy) else $error("result while idle");
   a_filter_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.action == bwf_pkg::ACT_FILTER) |=> req_busy)
      else $error("filter transfer did not start");
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.action != bwf_pkg::ACT_FILTER) |=> !req_busy)
      else $error("write transfer left block busy");
`endif

endmodule

### sv/bwf_divider.sv
module bwf_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bwf_pkg::NUM_W-1:0]        numer,
   input  logic [bwf_pkg::DEN_W-1:0]        denom,
   output bwf_pkg::div_ctl_type             status,
   output logic [bwf_pkg::QUOT_W-1:0]       quotient
);

   localparam int STEPS = bwf_pkg::NUM_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int REM_W = bwf_pkg::DEN_W + 1;

   logic [bwf_pkg::NUM_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [bwf_pkg::DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [REM_W-1:0]          trial;
   logic [REM_W-1:0]          shifted;

   always_comb begin
      shifted = {rem_ff[REM_W-2:0], quo_ff[bwf_pkg::NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[REM_W-1]) begin
            rem_in = trial;
            quo_in = {quo_ff[bwf_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[bwf_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign status.zero  = (den_ff == '0);
   assign quotient     = (quo_ff > bwf_pkg::NUM_W'(255)) ? 8'hFF
                                                         : quo_ff[bwf_pkg::QUOT_W-1:0];

endmodule
